>>> design/portset_binding_table_lookup_defines.svh
// Assertion macros for the binding table.
`ifndef PORTSET_BINDING_TABLE_LOOKUP_DEFINES_SVH
`define PORTSET_BINDING_TABLE_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PBTL_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define PBTL_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

>>> design/pbtl_pkg.sv
package pbtl_pkg;

	localparam logic [2:0] FUNC_INSERT = 3'd0;
	localparam logic [2:0] FUNC_REMOVE = 3'd1;
	localparam logic [2:0] FUNC_FIND   = 3'd2;
	localparam logic [2:0] FUNC_FLUSH  = 3'd3;
	localparam logic [2:0] FUNC_COUNT  = 3'd4;

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_FIND,
		OP_FLUSH,
		OP_COUNT
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_APPLY,
		ST_RDWAIT,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] ipv4_addr;
		logic [15:0] portset_mask;
		logic [15:0] portset_index;
		logic [15:0] port;
		logic [63:0] initiator_v6_hi;
		logic [63:0] initiator_v6_lo;
		logic [63:0] concentrator_v6_hi;
		logic [63:0] concentrator_v6_lo;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic        status;
		logic [6:0]  live_entries;
		logic [63:0] found_initiator_hi;
		logic [63:0] found_initiator_lo;
		logic [63:0] found_concentrator_hi;
		logic [63:0] found_concentrator_lo;
	} rsp_t;

	typedef struct packed {
		logic [31:0] ipv4;
		logic [15:0] mask;
		logic [15:0] index;
	} key_t;

	typedef struct packed {
		logic [63:0] ini_hi;
		logic [63:0] ini_lo;
		logic [63:0] con_hi;
		logic [63:0] con_lo;
	} pay_t;

	typedef struct packed {
		op_t         op;
		key_t        key;
		logic [15:0] port;
		pay_t        pay;
	} cmd_t;

	// Handshake between the queue and the engine.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_if_t;

endpackage

>>> design/pbtl_front.sv
module pbtl_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pbtl_pkg::req_t req,
	output pbtl_pkg::cmd_if_t cmd_out,
	input  logic           cmd_take
);
	import pbtl_pkg::*;

	cmd_t       q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;
	logic       pop;

	always_comb begin
		case (req.func)
			FUNC_INSERT: cls.op = OP_INSERT;
			FUNC_REMOVE: cls.op = OP_REMOVE;
			FUNC_FIND:   cls.op = OP_FIND;
			FUNC_FLUSH:  cls.op = OP_FLUSH;
			FUNC_COUNT:  cls.op = OP_COUNT;
			default:     cls.op = OP_COUNT;
		endcase
		cls.key.ipv4   = req.ipv4_addr;
		cls.key.mask   = req.portset_mask;
		cls.key.index  = req.portset_index;
		cls.port       = req.port;
		cls.pay.ini_hi = req.initiator_v6_hi;
		cls.pay.ini_lo = req.initiator_v6_lo;
		cls.pay.con_hi = req.concentrator_v6_hi;
		cls.pay.con_lo = req.concentrator_v6_lo;
	end

	assign req_stall     = (cnt_q == 2'd2);
	assign push          = req_valid && !req_stall;
	assign cmd_out.valid = (cnt_q != 2'd0);
	assign cmd_out.cmd   = q_mem_q[rd_ptr_q];
	assign pop           = cmd_out.valid && cmd_take;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> design/pbtl_back.sv
module pbtl_back #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pbtl_pkg::cmd_if_t cmd_in,
	output logic              cmd_take,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output pbtl_pkg::rsp_t    rsp
);
	import pbtl_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	key_t    key_mem [TABLE_ENTRIES];
	pay_t    pay_mem [TABLE_ENTRIES];

	st_t     state_q, state_nx;
	cmd_t    cur_q;
	logic [IW-1:0] addr_q;
	logic    cmp_v_s1;
	logic [IW-1:0] cmp_idx_s1;
	key_t    key_rd_s1;
	pay_t    pay_rd_q;
	logic    match_f_q, free_f_q, best_f_q, stat_q;
	logic [IW-1:0] match_idx_q, free_idx_q, best_idx_q;
	logic [15:0] best_mask_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CW-1:0] count_q;
	rsp_t    res_q;
	logic    res_v_q;

	logic    do_load;
	logic    scanning;
	logic    applying;
	logic    slot_v;
	logic    key_eq;
	logic [15:0] inv_mask;
	logic    find_eq;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_in.valid) begin
					if (cmd_in.cmd.op == OP_INSERT || cmd_in.cmd.op == OP_REMOVE ||
					    cmd_in.cmd.op == OP_FIND) begin
						state_nx = ST_SCAN;
					end else begin
						state_nx = ST_APPLY;
					end
				end
			end
			ST_SCAN: begin
				if (addr_q == LAST) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_nx = ST_APPLY;
			ST_APPLY:  state_nx = ST_RDWAIT;
			ST_RDWAIT: state_nx = ST_DONE;
			ST_DONE: begin
				if (!res_v_q || !rsp_stall) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_take = 1'b0;
		scanning = 1'b0;
		applying = 1'b0;
		do_load  = 1'b0;
		case (state_q)
			ST_IDLE:  cmd_take = cmd_in.valid;
			ST_SCAN:  scanning = 1'b1;
			ST_APPLY: applying = 1'b1;
			ST_DONE:  do_load  = !res_v_q || !rsp_stall;
			default: begin
			end
		endcase
	end

	// compare on the registered key
	assign slot_v   = valid_q[cmp_idx_s1];
	assign key_eq   = slot_v && key_rd_s1 == cur_q.key;
	assign inv_mask = ~key_rd_s1.mask;
	assign find_eq  = slot_v && key_rd_s1.ipv4 == cur_q.key.ipv4 &&
	                  ((inv_mask & (inv_mask + 16'd1)) == 16'd0) &&
	                  key_rd_s1.index == (cur_q.port & key_rd_s1.mask);

	always_ff @(posedge clk) begin
		key_rd_s1 <= key_mem[addr_q];
		pay_rd_q  <= pay_mem[best_idx_q];
		if (applying && cur_q.op == OP_INSERT && (match_f_q || free_f_q)) begin
			key_mem[match_f_q ? match_idx_q : free_idx_q] <= cur_q.key;
			pay_mem[match_f_q ? match_idx_q : free_idx_q] <= cur_q.pay;
		end
		if (cmd_take) begin
			cur_q <= cmd_in.cmd;
		end
		cmp_idx_s1 <= addr_q;
		if (cmp_v_s1) begin
			if (key_eq && !match_f_q) begin
				match_idx_q <= cmp_idx_s1;
			end
			if (!slot_v && !free_f_q) begin
				free_idx_q <= cmp_idx_s1;
			end
			// longer prefix masks are numerically larger
			if (find_eq && (!best_f_q || key_rd_s1.mask > best_mask_q)) begin
				best_mask_q <= key_rd_s1.mask;
				best_idx_q  <= cmp_idx_s1;
			end
		end
		if (do_load) begin
			res_q.hit          <= cur_q.op == OP_FIND && best_f_q;
			res_q.status       <= stat_q;
			res_q.live_entries <= 7'(count_q);
			if (cur_q.op == OP_FIND && best_f_q) begin
				res_q.found_initiator_hi    <= pay_rd_q.ini_hi;
				res_q.found_initiator_lo    <= pay_rd_q.ini_lo;
				res_q.found_concentrator_hi <= pay_rd_q.con_hi;
				res_q.found_concentrator_lo <= pay_rd_q.con_lo;
			end else begin
				res_q.found_initiator_hi    <= 64'd0;
				res_q.found_initiator_lo    <= 64'd0;
				res_q.found_concentrator_hi <= 64'd0;
				res_q.found_concentrator_lo <= 64'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			addr_q    <= '0;
			cmp_v_s1  <= 1'b0;
			match_f_q <= 1'b0;
			free_f_q  <= 1'b0;
			best_f_q  <= 1'b0;
			stat_q    <= 1'b0;
			valid_q   <= '0;
			count_q   <= '0;
			res_v_q   <= 1'b0;
		end else begin
			state_q  <= state_nx;
			cmp_v_s1 <= scanning;
			if (cmd_take) begin
				addr_q    <= '0;
				match_f_q <= 1'b0;
				free_f_q  <= 1'b0;
				best_f_q  <= 1'b0;
				stat_q    <= 1'b0;
			end else if (scanning && addr_q != LAST) begin
				addr_q <= addr_q + IW'(1);
			end
			if (cmp_v_s1) begin
				if (key_eq) begin
					match_f_q <= 1'b1;
				end
				if (!slot_v) begin
					free_f_q <= 1'b1;
				end
				if (find_eq) begin
					best_f_q <= 1'b1;
				end
			end
			if (applying) begin
				case (cur_q.op)
					OP_INSERT: begin
						if (match_f_q) begin
							valid_q[match_idx_q] <= 1'b1;
						end else if (free_f_q) begin
							valid_q[free_idx_q] <= 1'b1;
							count_q <= count_q + CW'(1);
						end else begin
							stat_q <= 1'b1;
						end
					end
					OP_REMOVE: begin
						if (match_f_q) begin
							valid_q[match_idx_q] <= 1'b0;
							count_q <= count_q - CW'(1);
						end
					end
					OP_FLUSH: begin
						valid_q <= '0;
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (do_load) begin
				res_v_q <= 1'b1;
			end else if (res_v_q && !rsp_stall) begin
				res_v_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = res_v_q;
	assign rsp       = res_q;

endmodule

>>> design/portset_binding_table_lookup.sv
// Channel | Beat type | Flow
// req     | req_t     | req_valid in, req_stall out
// rsp     | rsp_t     | rsp_valid out, rsp_stall in
//
// Insert, remove and find sweep the key memory one slot a cycle through its
// single read port. Flush, count and unused codes skip the sweep. A two-beat
// queue takes requests while a result waits. Reset clears valid bits and
// count at once; no sweep is needed.
module portset_binding_table_lookup #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pbtl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pbtl_pkg::rsp_t rsp
);
	import pbtl_pkg::*;

	`include "portset_binding_table_lookup_defines.svh"

	cmd_if_t cmd;
	logic    cmd_take;

	pbtl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_out   (cmd),
		.cmd_take  (cmd_take)
	);

	pbtl_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd),
		.cmd_take  (cmd_take),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	`PBTL_ASSERT_NOW(a_take_needs_cmd, cmd_take, cmd.valid, "engine took from empty queue")
	`PBTL_ASSERT_NOW(a_hit_no_drop, rsp_valid, !(rsp.hit && rsp.status), "hit with drop flag")
	`PBTL_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp.hit, ~|rsp.found_initiator_hi, "miss with data")
	`PBTL_ASSERT_NEXT(a_take_gap, cmd_take, !cmd_take, "back-to-back take")

endmodule
